### design/tcec_pkg.sv
// Package: shared types, constants and the period-to-note lookup for the cell converter.
`default_nettype none

package tcec_pkg;

  localparam int ROWS_PER_TRACK   = 64;
  localparam int INSTRUMENT_SLOTS = 32;
  localparam int SLOT_W           = $clog2(INSTRUMENT_SLOTS);
  localparam int MAX_EVENTS       = 4;
  localparam int EV_IDX_W         = $clog2(MAX_EVENTS);
  localparam int EV_CNT_W         = $clog2(MAX_EVENTS + 1);

  localparam int ROW_W   = $clog2(ROWS_PER_TRACK);
  localparam int CODE_W  = 5;
  localparam int NOTE_W  = 7;
  localparam int VALUE_W = 8;
  localparam int VOL_W   = 7;

  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS_PER_TRACK - 1);
  localparam logic [7:0]       NO_INSTR  = 8'hF0;
  localparam logic [7:0]       NO_VOLUME = 8'hFF;
  localparam logic [7:0]       VOL_MAX   = 8'd64;
  localparam logic [7:0]       BEND_MAX  = 8'd127;
  localparam logic [7:0]       TEMPO_LIM = 8'd32;
  localparam logic [7:0]       SLIDE_UP  = 8'h10;
  localparam int               NOTE_BASE = 36;
  localparam int               PERIODS   = 61;

  // Effect commands (low nibble of cell byte 2).
  localparam logic [3:0] FX_ARPEGGIO = 4'h0;
  localparam logic [3:0] FX_PORT_UP  = 4'h1;
  localparam logic [3:0] FX_PORT_DN  = 4'h2;
  localparam logic [3:0] FX_TONE     = 4'h3;
  localparam logic [3:0] FX_VIBRATO  = 4'h4;
  localparam logic [3:0] FX_TONEVOL  = 4'h5;
  localparam logic [3:0] FX_VIBRVOL  = 4'h6;
  localparam logic [3:0] FX_TREMOLO  = 4'h7;
  localparam logic [3:0] FX_OFFSET   = 4'h9;
  localparam logic [3:0] FX_VOLSLIDE = 4'hA;
  localparam logic [3:0] FX_GOTO     = 4'hB;
  localparam logic [3:0] FX_VOLUME   = 4'hC;
  localparam logic [3:0] FX_BREAK    = 4'hD;
  localparam logic [3:0] FX_EXTENDED = 4'hE;
  localparam logic [3:0] FX_TEMPO    = 4'hF;

  // Extended sub-effects (high nibble of the parameter).
  localparam logic [3:0] EX_FINE_UP  = 4'h1;
  localparam logic [3:0] EX_FINE_DN  = 4'h2;
  localparam logic [3:0] EX_RETRIG   = 4'h9;
  localparam logic [3:0] EX_FVOL_UP  = 4'hA;
  localparam logic [3:0] EX_FVOL_DN  = 4'hB;

  typedef enum logic [CODE_W-1:0] {
    EV_NOTE     = 5'd0,
    EV_BENDTO   = 5'd1,
    EV_VOLABS   = 5'd2,
    EV_INSTR    = 5'd3,
    EV_TEMPO    = 5'd4,
    EV_GOTO     = 5'd5,
    EV_BREAK    = 5'd6,
    EV_VOLSLIDE = 5'd7,
    EV_BEND     = 5'd8,
    EV_VIBRATO  = 5'd9,
    EV_TONEVOL  = 5'd10,
    EV_VIBRVOL  = 5'd11,
    EV_TREMOLO  = 5'd12,
    EV_ARPEGGIO = 5'd13,
    EV_OFFSET   = 5'd14,
    EV_RETRIG   = 5'd15,
    EV_FINETUNE = 5'd16,
    EV_FINEVOL  = 5'd17,
    EV_END      = 5'd18
  } ev_code_t;

  typedef struct packed {
    logic [ROW_W-1:0]   tick;
    ev_code_t           code;
    logic [NOTE_W-1:0]  note;
    logic [VALUE_W-1:0] value;
  } event_t;

  typedef struct packed {
    event_t [MAX_EVENTS-1:0] ev;
    logic [EV_CNT_W-1:0]     cnt;
  } ev_batch_t;

  typedef struct packed {
    logic             mode;
    logic [ROW_W-1:0] row;
    logic [7:0]       cell_byte0;
    logic [7:0]       cell_byte1;
    logic [7:0]       cell_byte2;
    logic [7:0]       cell_byte3;
    logic [4:0]       table_index;
    logic [6:0]       table_volume;
  } cell_t;

  typedef struct packed {
    logic [7:0] cur_instr;
    logic       nonempty;
  } track_state_t;

  localparam logic [11:0] PERIOD_TABLE [PERIODS] = '{
    12'd1712, 12'd1616, 12'd1524, 12'd1440, 12'd1356, 12'd1280,
    12'd1208, 12'd1140, 12'd1076, 12'd1016, 12'd960,  12'd912,
    12'd856,  12'd808,  12'd762,  12'd720,  12'd678,  12'd640,
    12'd604,  12'd570,  12'd538,  12'd508,  12'd480,  12'd453,
    12'd428,  12'd404,  12'd381,  12'd360,  12'd339,  12'd320,
    12'd302,  12'd285,  12'd269,  12'd254,  12'd240,  12'd226,
    12'd214,  12'd202,  12'd190,  12'd180,  12'd170,  12'd160,
    12'd151,  12'd143,  12'd135,  12'd127,  12'd120,  12'd113,
    12'd107,  12'd101,  12'd95,   12'd90,   12'd85,   12'd80,
    12'd75,   12'd71,   12'd67,   12'd63,   12'd60,   12'd56,
    12'd0
  };

  // The first table entry that the period is not below gives the note.
  function automatic logic [NOTE_W-1:0] period_to_note(input logic [11:0] period);
    logic [NOTE_W-1:0] n;
    n = NOTE_W'(NOTE_BASE + PERIODS - 1);
    for (int i = PERIODS - 1; i >= 0; i--) begin
      if (period >= PERIOD_TABLE[i]) begin
        n = NOTE_W'(NOTE_BASE + i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### design/tcec_if.sv
// Interfaces: the cell input channel and the event output channel.
`default_nettype none

interface tcec_cell_if;
  import tcec_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [ROW_W-1:0] row;
  logic [7:0]       cell_byte0;
  logic [7:0]       cell_byte1;
  logic [7:0]       cell_byte2;
  logic [7:0]       cell_byte3;
  logic [4:0]       table_index;
  logic [6:0]       table_volume;

  modport source (output valid, mode, row, cell_byte0, cell_byte1, cell_byte2, cell_byte3,
                  table_index, table_volume, input ready);
  modport sink (input valid, mode, row, cell_byte0, cell_byte1, cell_byte2, cell_byte3,
                table_index, table_volume, output ready);
endinterface

interface tcec_event_if;
  import tcec_pkg::*;
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   tick;
  logic [CODE_W-1:0]  event_code;
  logic [NOTE_W-1:0]  note_number;
  logic [VALUE_W-1:0] event_value;
  logic               last;

  modport source (output valid, tick, event_code, note_number, event_value, last,
                  input ready);
  modport sink (input valid, tick, event_code, note_number, event_value, last,
                output ready);
endinterface

`default_nettype wire

### design/tcec_decode.sv
// Cell decoder: turns one pattern cell into its batch of up to four events.
`default_nettype none

module tcec_decode (
  input  tcec_pkg::cell_t                   in_cell,
  input  tcec_pkg::track_state_t            state,
  input  logic [tcec_pkg::VOL_W-1:0]        tbl_vol,
  output logic [tcec_pkg::SLOT_W-1:0]       tbl_addr,
  output tcec_pkg::track_state_t            state_next,
  output tcec_pkg::ev_batch_t               batch
);
  import tcec_pkg::*;

  function automatic event_t mk_ev(input logic [ROW_W-1:0] t, input ev_code_t c,
                                   input logic [NOTE_W-1:0] nn, input logic [7:0] v);
    event_t e;
    e.tick  = t;
    e.code  = c;
    e.note  = nn;
    e.value = v;
    return e;
  endfunction

  function automatic logic [7:0] slide(input logic [7:0] d);
    return (d >= SLIDE_UP) ? (d >> 4) : (8'd0 - d);
  endfunction

  logic [11:0]         period;
  logic [NOTE_W-1:0]   note;
  logic [3:0]          cmd;
  logic [7:0]          d;
  logic                has_cmd;
  logic                is_volfx;
  logic [7:0]          vol;
  logic [7:0]          vol_tbl;
  logic [4:0]          ins;
  logic [4:0]          z;
  logic [7:0]          z_ext;
  logic [7:0]          cur;
  logic                ne;
  logic [EV_CNT_W-1:0] n;
  event_t [MAX_EVENTS-1:0] ev;
  logic                fx_en;
  ev_code_t            fx_code;
  logic [7:0]          fx_val;
  logic [7:0]          bend;

  assign period   = {in_cell.cell_byte0[3:0], in_cell.cell_byte1};
  assign cmd      = in_cell.cell_byte2[3:0];
  assign d        = in_cell.cell_byte3;
  assign ins      = {in_cell.cell_byte0[4], in_cell.cell_byte2[7:4]};
  assign z        = ins - 5'd1;
  assign z_ext    = {3'd0, z};
  assign tbl_addr = SLOT_W'(z);
  // Instruments beyond the table read as volume zero.
  assign vol_tbl  = (int'(z) < INSTRUMENT_SLOTS) ? {1'b0, tbl_vol} : 8'd0;
  assign note     = period_to_note(period);
  assign bend     = (d > BEND_MAX) ? BEND_MAX : d;

  // Effect translation, independent of the note and instrument part.
  always_comb begin
    fx_en   = 1'b1;
    fx_code = EV_TEMPO;
    fx_val  = d;
    case (cmd)
      FX_TEMPO: begin
        fx_en = (d != 8'd0) && (d < TEMPO_LIM);
      end
      FX_GOTO:     fx_code = EV_GOTO;
      FX_BREAK: begin
        fx_code = EV_BREAK;
        fx_val  = 8'd0;
      end
      FX_VOLSLIDE: begin
        fx_code = EV_VOLSLIDE;
        fx_val  = slide(d);
      end
      FX_PORT_DN: begin
        fx_code = EV_BEND;
        fx_val  = bend;
      end
      FX_PORT_UP: begin
        fx_code = EV_BEND;
        fx_val  = 8'd0 - bend;
      end
      FX_VIBRATO:  fx_code = EV_VIBRATO;
      FX_TONEVOL: begin
        fx_code = EV_TONEVOL;
        fx_val  = slide(d);
      end
      FX_VIBRVOL: begin
        fx_code = EV_VIBRVOL;
        fx_val  = slide(d);
      end
      FX_TREMOLO:  fx_code = EV_TREMOLO;
      FX_ARPEGGIO: begin
        fx_code = EV_ARPEGGIO;
        fx_en   = (d != 8'd0);
      end
      FX_OFFSET:   fx_code = EV_OFFSET;
      FX_EXTENDED: begin
        fx_val = {4'd0, d[3:0]};
        case (d[7:4])
          EX_RETRIG:  fx_code = EV_RETRIG;
          EX_FINE_UP: begin
            fx_code = EV_FINETUNE;
            fx_val  = 8'd0 - {4'd0, d[3:0]};
          end
          EX_FINE_DN: fx_code = EV_FINETUNE;
          EX_FVOL_UP: fx_code = EV_FINEVOL;
          EX_FVOL_DN: begin
            fx_code = EV_FINEVOL;
            fx_val  = 8'd0 - {4'd0, d[3:0]};
          end
          default:    fx_en = 1'b0;
        endcase
      end
      default: fx_en = 1'b0;
    endcase
  end

  // Events are appended in order; the count never passes the batch size.
  always_comb begin
    ev       = '0;
    n        = '0;
    has_cmd  = (cmd != FX_TONE);
    is_volfx = (cmd == FX_VOLUME);
    cur      = (in_cell.row == '0) ? NO_INSTR : state.cur_instr;
    ne       = (in_cell.row == '0) ? 1'b0 : state.nonempty;

    if (!has_cmd) begin
      ev[n[EV_IDX_W-1:0]] = mk_ev(in_cell.row, EV_BENDTO, '0, d);
      n = n + EV_CNT_W'(1);
    end
    vol = is_volfx ? ((d > VOL_MAX) ? VOL_MAX : d) : NO_VOLUME;

    if ((ins != 5'd0) && (period == 12'd0)) begin
      if (z_ext == cur) begin
        ev[n[EV_IDX_W-1:0]] = mk_ev(in_cell.row, EV_VOLABS, '0, vol_tbl);
      end else begin
        ev[n[EV_IDX_W-1:0]] = mk_ev(in_cell.row, EV_INSTR, '0, z_ext);
      end
      n   = n + EV_CNT_W'(1);
      cur = z_ext;
    end

    if (period != 12'd0) begin
      if (ins != 5'd0) begin
        if (z_ext != cur) begin
          ev[n[EV_IDX_W-1:0]] = mk_ev(in_cell.row, EV_INSTR, '0, z_ext);
          n   = n + EV_CNT_W'(1);
          cur = z_ext;
        end
        if (!is_volfx) begin
          vol = vol_tbl;
        end
      end
      ev[n[EV_IDX_W-1:0]] = mk_ev(in_cell.row, EV_NOTE, note, vol);
      n = n + EV_CNT_W'(1);
    end else begin
      if (ins != 5'd0) begin
        vol = vol_tbl;
      end
      if (vol <= VOL_MAX) begin
        ev[n[EV_IDX_W-1:0]] = mk_ev(in_cell.row, EV_VOLABS, '0, vol);
        n = n + EV_CNT_W'(1);
      end
    end

    if (has_cmd && fx_en) begin
      ev[n[EV_IDX_W-1:0]] = mk_ev(in_cell.row, fx_code, '0, fx_val);
      n = n + EV_CNT_W'(1);
    end

    ne = ne | (n != '0);
    if ((in_cell.row == LAST_ROW) && ne) begin
      ev[n[EV_IDX_W-1:0]] = mk_ev(in_cell.row, EV_END, '0, 8'd0);
      n = n + EV_CNT_W'(1);
    end

    state_next.cur_instr = cur;
    state_next.nonempty  = ne;
    batch.ev             = ev;
    batch.cnt            = n;
  end

endmodule

`default_nettype wire

### design/tracker_cell_to_event_converter.sv
// Top level: input register, cell decoder, track state, volume table and event buffer.
`default_nettype none

// Each accepted beat is first held in an input register. Once the event buffer is
// free, the cell decoder turns a pattern cell (mode 0) into up to four events,
// updates the current instrument and the track's nonempty flag, and loads the
// events into a four-entry event buffer; a volume table write (mode 1) is applied
// from the input register without waiting and produces no events. The buffer
// drives the output channel one event per beat, with last set on the final event
// of the cell. Each cell passes the input register and then the event buffer
// before its first event appears. The single output port sets the pace: a cell
// holds the output until all its events are taken, and a waiting cell is decoded
// in the very cycle in which the last event of the previous one is taken. The
// input register takes one further beat while the buffer still drains, and volume
// table writes pass even while events are pending. The 32-entry volume table sits
// in flip-flops and is cleared by reset; written volumes saturate at 64.
module tracker_cell_to_event_converter (
  input  logic          clk,
  input  logic          rst,
  tcec_cell_if.sink     cells,
  tcec_event_if.source  events
);
  import tcec_pkg::*;

  // Input register.
  cell_t cell_q;
  logic  in_vld;

  // Track state and volume table.
  track_state_t             state;
  track_state_t             state_next;
  logic [VOL_W-1:0]         vol_table [INSTRUMENT_SLOTS];
  logic [SLOT_W-1:0]        tbl_addr;
  logic [SLOT_W-1:0]        wr_addr;

  // Event buffer.
  event_t [MAX_EVENTS-1:0]  ev_buf;
  logic [EV_CNT_W-1:0]      ev_cnt;
  logic [EV_IDX_W-1:0]      ev_idx;
  ev_batch_t                batch;

  logic   pending;
  logic   out_last;
  logic   out_fire;
  logic   buf_free;
  logic   consume;
  logic   load;
  event_t cur_ev;

  tcec_decode u_decode (
    .in_cell    (cell_q),
    .state      (state),
    .tbl_vol    (vol_table[tbl_addr]),
    .tbl_addr   (tbl_addr),
    .state_next (state_next),
    .batch      (batch)
  );

  assign pending  = (ev_cnt != '0);
  assign out_last = ({1'b0, ev_idx} == (ev_cnt - EV_CNT_W'(1)));
  assign out_fire = pending && events.ready;
  assign buf_free = !pending || (out_fire && out_last);

  // A table write never waits for the buffer; a cell needs the buffer free.
  assign consume = in_vld && (cell_q.mode || buf_free);
  assign load    = consume && !cell_q.mode;
  assign wr_addr = SLOT_W'(cell_q.table_index);

  assign cells.ready = !in_vld || consume;

  assign cur_ev             = ev_buf[ev_idx];
  assign events.valid       = pending;
  assign events.tick        = cur_ev.tick;
  assign events.event_code  = cur_ev.code;
  assign events.note_number = cur_ev.note;
  assign events.event_value = cur_ev.value;
  assign events.last        = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld          <= 1'b0;
      state.cur_instr <= NO_INSTR;
      state.nonempty  <= 1'b0;
      ev_cnt          <= '0;
      ev_idx          <= '0;
      for (int i = 0; i < INSTRUMENT_SLOTS; i++) begin
        vol_table[i] <= '0;
      end
    end else begin
      if (cells.ready) begin
        in_vld <= cells.valid;
      end
      // Writes to an index beyond the table are dropped.
      if (consume && cell_q.mode && (int'(cell_q.table_index) < INSTRUMENT_SLOTS)) begin
        vol_table[wr_addr] <= ({1'b0, cell_q.table_volume} > VOL_MAX)
                              ? VOL_W'(VOL_MAX) : cell_q.table_volume;
      end
      if (load) begin
        state  <= state_next;
        ev_cnt <= batch.cnt;
        ev_idx <= '0;
      end else if (out_fire) begin
        if (out_last) begin
          ev_cnt <= '0;
          ev_idx <= '0;
        end else begin
          ev_idx <= ev_idx + EV_IDX_W'(1);
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cells.ready && cells.valid) begin
      cell_q.mode         <= cells.mode;
      cell_q.row          <= cells.row;
      cell_q.cell_byte0   <= cells.cell_byte0;
      cell_q.cell_byte1   <= cells.cell_byte1;
      cell_q.cell_byte2   <= cells.cell_byte2;
      cell_q.cell_byte3   <= cells.cell_byte3;
      cell_q.table_index  <= cells.table_index;
      cell_q.table_volume <= cells.table_volume;
    end
    if (load) begin
      ev_buf <= batch.ev;
    end
  end

  // The beat being shown always lies inside the loaded batch.
  a_idx_in_batch: assert property (@(posedge clk) disable iff (rst)
    events.valid |-> ({1'b0, ev_idx} < ev_cnt))
    else $error("event index outside loaded batch");

  // A new batch only replaces the buffer as its final beat leaves.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load && pending) |-> (events.ready && out_last))
    else $error("event batch overwritten while pending");

  // After the final beat of a batch, output goes idle unless a new batch came in.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_last && !load) |=> !events.valid)
    else $error("output still valid after last beat");

  // Input only stalls while the input register holds a beat.
  a_stall_has_beat: assert property (@(posedge clk) disable iff (rst)
    !cells.ready |-> in_vld)
    else $error("input stalled with empty input register");

  // A decoded batch never exceeds the buffer depth.
  a_batch_size: assert property (@(posedge clk) disable iff (rst)
    load |-> (batch.cnt <= EV_CNT_W'(MAX_EVENTS)))
    else $error("decoded batch larger than buffer");

endmodule

`default_nettype wire
